// File: design/sdz_pkg.sv
package sdz_pkg;

  // Default sample width and fixed-point layout (Q2.14)
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS       = 14;
  localparam int THR_BITS        = 15;
  localparam logic [THR_BITS-1:0] ONE_Q14 = 15'd16384;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = THR_BITS;
  localparam logic [THR_BITS-1:0] LOWER_RST = 15'd3277;
  localparam logic [THR_BITS-1:0] UPPER_RST = 15'd16384;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PLAYER = 2'd0,
    CFG_RADIAL = 2'd1,
    CFG_LOWER  = 2'd2,
    CFG_UPPER  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_BOOL = 2'd0,
    KIND_1D   = 2'd1,
    KIND_2D   = 2'd2,
    KIND_3D   = 2'd3
  } kind_t;

  // Work class decided at the front
  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_AXIAL = 3'd1,
    OP_RAD1  = 3'd2,
    OP_RAD2  = 3'd3,
    OP_RAD3  = 3'd4
  } op_t;

  typedef struct packed {
    logic                player_attached;
    logic                radial_mode;
    logic [THR_BITS-1:0] lower;
    logic [THR_BITS-1:0] upper;
  } cfg_t;

endpackage

// File: design/sdz_in_if.sv
interface sdz_in_if #(
  parameter int SAMPLE_BITS = sdz_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    value_kind;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic signed [SAMPLE_BITS-1:0] y_in;
  logic signed [SAMPLE_BITS-1:0] z_in;

  modport source (output valid, value_kind, x_in, y_in, z_in, input ready);
  modport sink   (input valid, value_kind, x_in, y_in, z_in, output ready);
endinterface

// File: design/sdz_out_if.sv
interface sdz_out_if #(
  parameter int SAMPLE_BITS = sdz_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] x_out;
  logic signed [SAMPLE_BITS-1:0] y_out;
  logic signed [SAMPLE_BITS-1:0] z_out;

  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

// File: design/sdz_front.sv
module sdz_front #(
  parameter int SAMPLE_BITS = sdz_pkg::SAMPLE_BITS_DEF
) (
  input  sdz_pkg::cfg_t                 cfg,
  input  logic [1:0]                    kind,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] y,
  input  logic signed [SAMPLE_BITS-1:0] z,
  output sdz_pkg::op_t                  op,
  output logic signed [SAMPLE_BITS-1:0] xo,
  output logic signed [SAMPLE_BITS-1:0] yo,
  output logic signed [SAMPLE_BITS-1:0] zo,
  output logic [SAMPLE_BITS-1:0]        ax,
  output logic [SAMPLE_BITS-1:0]        ay,
  output logic [SAMPLE_BITS-1:0]        az
);

  // Classify the request
  always_comb begin
    op = sdz_pkg::OP_PASS;
    if (sdz_pkg::kind_t'(kind) != sdz_pkg::KIND_BOOL && cfg.player_attached) begin
      if (!cfg.radial_mode) begin
        op = sdz_pkg::OP_AXIAL;
      end else begin
        case (sdz_pkg::kind_t'(kind))
          sdz_pkg::KIND_1D: op = sdz_pkg::OP_RAD1;
          sdz_pkg::KIND_2D: op = sdz_pkg::OP_RAD2;
          sdz_pkg::KIND_3D: op = sdz_pkg::OP_RAD3;
          default:          op = sdz_pkg::OP_PASS;
        endcase
      end
    end
  end

  // Clear Z for a planar radial request
  assign xo = x;
  assign yo = y;
  assign zo = (op == sdz_pkg::OP_RAD2) ? '0 : z;

  // Take magnitudes; the most negative code maps to its true size unsigned
  assign ax = xo[SAMPLE_BITS-1] ? SAMPLE_BITS'(-xo) : SAMPLE_BITS'(xo);
  assign ay = yo[SAMPLE_BITS-1] ? SAMPLE_BITS'(-yo) : SAMPLE_BITS'(yo);
  assign az = zo[SAMPLE_BITS-1] ? SAMPLE_BITS'(-zo) : SAMPLE_BITS'(zo);

endmodule

// File: design/sdz_fifo.sv
module sdz_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int DEPTH = 4;
  localparam int PTR   = $clog2(DEPTH);

  logic [W-1:0] mem_r [DEPTH];
  logic [PTR-1:0] wr_r, rd_r;
  logic [PTR:0]   cnt_r;

  assign full  = (cnt_r == (PTR+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/sdz_divpipe.sv
module sdz_divpipe #(
  parameter int LANES = 3,
  parameter int QB    = 14,
  parameter int DW    = 15,
  parameter int SW    = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][DW-1:0]       in_rem,
  input  logic [LANES-1:0][QB-1:0]       in_low,
  input  logic [DW-1:0]                  in_den,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  output logic [LANES-1:0][QB-1:0]       out_quo,
  output logic [SW-1:0]                  out_side
);

  // Restoring division, one quotient bit per stage, divisor shared by the lanes
  logic                     v_r    [QB];
  logic [LANES-1:0][DW-1:0] rem_r  [QB];
  logic [LANES-1:0][QB-1:0] low_r  [QB];
  logic [LANES-1:0][QB-1:0] quo_r  [QB];
  logic [DW-1:0]            den_r  [QB];
  logic [SW-1:0]            side_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic          p_v;
    logic [DW-1:0] p_den;
    logic [SW-1:0] p_side;

    if (k == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_v    = v_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_side = side_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW-1:0] p_rem;
      logic [QB-1:0] p_low;
      logic [QB-1:0] p_quo;
      logic [DW:0]   trial;
      logic          ge;

      if (k == 0) begin : g_first
        assign p_rem = in_rem[l];
        assign p_low = in_low[l];
        assign p_quo = '0;
      end else begin : g_next
        assign p_rem = rem_r[k-1][l];
        assign p_low = low_r[k-1][l];
        assign p_quo = quo_r[k-1][l];
      end

      // Bring down one bit and try the subtract
      assign trial = {p_rem, p_low[QB-1]};
      assign ge    = (trial >= {1'b0, p_den});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];
          low_r[k][l] <= {p_low[QB-2:0], 1'b0};
          quo_r[k][l] <= {p_quo[QB-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= p_den;
        side_r[k] <= p_side;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_quo   = quo_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

// File: design/sdz_back.sv
module sdz_back #(
  parameter int SAMPLE_BITS = sdz_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdz_pkg::cfg_t                 cfg,
  input  logic                          src_valid,
  output logic                          src_pop,
  input  sdz_pkg::op_t                  src_op,
  input  logic signed [SAMPLE_BITS-1:0] src_x,
  input  logic signed [SAMPLE_BITS-1:0] src_y,
  input  logic signed [SAMPLE_BITS-1:0] src_z,
  input  logic [SAMPLE_BITS-1:0]        src_ax,
  input  logic [SAMPLE_BITS-1:0]        src_ay,
  input  logic [SAMPLE_BITS-1:0]        src_az,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic signed [SAMPLE_BITS-1:0] res_x,
  output logic signed [SAMPLE_BITS-1:0] res_y,
  output logic signed [SAMPLE_BITS-1:0] res_z
);

  localparam int N     = SAMPLE_BITS;
  localparam int TB    = sdz_pkg::THR_BITS;
  localparam int FB    = sdz_pkg::FRAC_BITS;
  localparam int LANES = 3;
  localparam int SQW   = 2 * N;
  localparam int RW    = N + 2;
  localparam int CW    = ((N > TB) ? N : TB) + 1;
  localparam int PW    = N + TB;

  typedef struct packed {
    sdz_pkg::op_t          op;
    logic signed [N-1:0]   x;
    logic signed [N-1:0]   y;
    logic signed [N-1:0]   z;
    logic [N-1:0]          ax;
    logic [N-1:0]          ay;
    logic [N-1:0]          az;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [N-1:0]     root;
    logic [LANES-1:0] zero;
    logic [LANES-1:0] sat;
  } sh_side_t;

  typedef struct packed {
    item_t                    it;
    logic [LANES-1:0][TB-1:0] s;
    logic                     mzero;
  } rs_side_t;

  logic en;

  // Advance the whole pipe unless a finished result is held
  assign en      = !res_valid || res_ready;
  assign src_pop = en && src_valid;

  // Square the magnitudes
  logic                    a_v_r;
  item_t                   a_it_r;
  logic [LANES-1:0][SQW-1:0] a_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_it_r    <= '{op: src_op, x: src_x, y: src_y, z: src_z,
                     ax: src_ax, ay: src_ay, az: src_az};
      a_sq_r[0] <= SQW'(src_ax) * SQW'(src_ax);
      a_sq_r[1] <= SQW'(src_ay) * SQW'(src_ay);
      a_sq_r[2] <= SQW'(src_az) * SQW'(src_az);
    end
  end

  // Sum the squares
  logic           b_v_r;
  item_t          b_it_r;
  logic [SQW-1:0] b_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_it_r  <= a_it_r;
      b_sum_r <= a_sq_r[0] + a_sq_r[1] + a_sq_r[2];
    end
  end

  // Square root, one root bit per stage
  logic           sq_v_r    [N];
  item_t          sq_it_r   [N];
  logic [RW-1:0]  sq_rem_r  [N];
  logic [N-1:0]   sq_root_r [N];
  logic [SQW-1:0] sq_sh_r   [N];

  for (genvar k = 0; k < N; k++) begin : g_sqrt
    logic           p_v;
    item_t          p_it;
    logic [RW-1:0]  p_rem;
    logic [N-1:0]   p_root;
    logic [SQW-1:0] p_sh;
    logic [RW-1:0]  trial;
    logic [RW-1:0]  tst;
    logic           ge;

    if (k == 0) begin : g_first
      assign p_v    = b_v_r;
      assign p_it   = b_it_r;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_sh   = b_sum_r;
    end else begin : g_next
      assign p_v    = sq_v_r[k-1];
      assign p_it   = sq_it_r[k-1];
      assign p_rem  = sq_rem_r[k-1];
      assign p_root = sq_root_r[k-1];
      assign p_sh   = sq_sh_r[k-1];
    end

    assign trial = {p_rem[RW-3:0], p_sh[SQW-1 -: 2]};
    assign tst   = {p_root, 2'b01};
    assign ge    = (trial >= tst);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_it_r[k]   <= p_it;
        sq_rem_r[k]  <= ge ? (trial - tst) : trial;
        sq_root_r[k] <= {p_root[N-2:0], ge};
        sq_sh_r[k]   <= {p_sh[SQW-3:0], 2'b00};
      end
    end
  end

  // Set up the shaping divide: dead band, saturation and numerator
  item_t                    sq_it;
  logic [N-1:0]             root_c;
  logic [TB-1:0]            lo_c;
  logic [TB-1:0]            den_c;
  logic                     inv_c;
  logic [LANES-1:0][N-1:0]  mag_c;
  logic [LANES-1:0][CW-1:0] aw_c;
  logic [LANES-1:0]         zero_c;
  logic [LANES-1:0]         sat_c;
  logic [LANES-1:0][TB-1:0] rem_c;

  assign sq_it  = sq_it_r[N-1];
  assign root_c = sq_root_r[N-1];

  always_comb begin
    lo_c  = (cfg.lower > sdz_pkg::ONE_Q14) ? sdz_pkg::ONE_Q14 : cfg.lower;
    inv_c = (cfg.upper <= lo_c);
    den_c = cfg.upper - lo_c;
    mag_c[0] = (sq_it.op == sdz_pkg::OP_RAD2 || sq_it.op == sdz_pkg::OP_RAD3) ?
               root_c : sq_it.ax;
    mag_c[1] = sq_it.ay;
    mag_c[2] = sq_it.az;
    for (int l = 0; l < LANES; l++) begin
      aw_c[l]   = CW'(mag_c[l]) - CW'(lo_c);
      zero_c[l] = (CW'(mag_c[l]) <= CW'(lo_c));
      sat_c[l]  = inv_c || (aw_c[l] >= CW'(den_c));
      rem_c[l]  = aw_c[l][TB-1:0];
    end
  end

  logic                     c_v_r;
  sh_side_t                 c_side_r;
  logic [LANES-1:0][TB-1:0] c_rem_r;
  logic [TB-1:0]            c_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= sq_v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= '{it: sq_it, root: root_c, zero: zero_c, sat: sat_c};
      c_rem_r  <= rem_c;
      c_den_r  <= den_c;
    end
  end

  // Shaping divide: (|v| - L) * 2^14 / (U - L)
  logic                     sh_v;
  logic [LANES-1:0][FB-1:0] sh_quo;
  sh_side_t                 sh_side;
  logic [$bits(sh_side_t)-1:0] sh_side_vec;

  sdz_divpipe #(
    .LANES (LANES),
    .QB    (FB),
    .DW    (TB),
    .SW    ($bits(sh_side_t))
  ) u_shape_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_rem    (c_rem_r),
    .in_low    ('0),
    .in_den    (c_den_r),
    .in_side   (c_side_r),
    .out_valid (sh_v),
    .out_quo   (sh_quo),
    .out_side  (sh_side_vec)
  );

  assign sh_side = sh_side_vec;

  // Resolve the shaped ratio per lane
  logic                     d_v_r;
  item_t                    d_it_r;
  logic [N-1:0]             d_root_r;
  logic [LANES-1:0][TB-1:0] d_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= sh_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_it_r   <= sh_side.it;
      d_root_r <= sh_side.root;
      for (int l = 0; l < LANES; l++) begin
        d_s_r[l] <= sh_side.zero[l] ? '0 :
                    sh_side.sat[l]  ? sdz_pkg::ONE_Q14 : {1'b0, sh_quo[l]};
      end
    end
  end

  // Scale each axis magnitude by the radial ratio
  logic                     e_v_r;
  rs_side_t                 e_side_r;
  logic [LANES-1:0][PW-1:0] e_prod_r;
  logic [N-1:0]             e_den_r;
  logic [LANES-1:0][N-1:0]  e_rem;
  logic [LANES-1:0][TB-1:0] e_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r    <= '{it: d_it_r, s: d_s_r, mzero: (d_root_r == '0)};
      e_den_r     <= d_root_r;
      e_prod_r[0] <= PW'(d_it_r.ax) * PW'(d_s_r[0]);
      e_prod_r[1] <= PW'(d_it_r.ay) * PW'(d_s_r[0]);
      e_prod_r[2] <= PW'(d_it_r.az) * PW'(d_s_r[0]);
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_split
    assign e_rem[l] = e_prod_r[l][PW-1 -: N];
    assign e_low[l] = e_prod_r[l][TB-1:0];
  end

  // Rescale divide: |a| * s / m
  logic                     rs_v;
  logic [LANES-1:0][TB-1:0] rs_quo;
  rs_side_t                 rs_side;
  logic [$bits(rs_side_t)-1:0] rs_side_vec;

  sdz_divpipe #(
    .LANES (LANES),
    .QB    (TB),
    .DW    (N),
    .SW    ($bits(rs_side_t))
  ) u_rescale_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_v_r),
    .in_rem    (e_rem),
    .in_low    (e_low),
    .in_den    (e_den_r),
    .in_side   (e_side_r),
    .out_valid (rs_v),
    .out_quo   (rs_quo),
    .out_side  (rs_side_vec)
  );

  assign rs_side = rs_side_vec;

  // Apply the sign of the original axis, wrapped to the sample width
  function automatic logic [N-1:0] apply_sign(input logic neg, input logic [TB-1:0] mag);
    logic [CW-1:0] w;
    w = neg ? (CW'(0) - CW'(mag)) : CW'(mag);
    return w[N-1:0];
  endfunction

  logic [N-1:0] fx_c, fy_c, fz_c;

  always_comb begin
    fx_c = rs_side.it.x;
    fy_c = rs_side.it.y;
    fz_c = rs_side.it.z;
    case (rs_side.it.op)
      sdz_pkg::OP_PASS: begin
        fx_c = rs_side.it.x;
      end
      sdz_pkg::OP_AXIAL: begin
        fx_c = apply_sign(rs_side.it.x[N-1], rs_side.s[0]);
        fy_c = apply_sign(rs_side.it.y[N-1], rs_side.s[1]);
        fz_c = apply_sign(rs_side.it.z[N-1], rs_side.s[2]);
      end
      sdz_pkg::OP_RAD1: begin
        fx_c = apply_sign(rs_side.it.x[N-1], rs_side.s[0]);
      end
      sdz_pkg::OP_RAD2, sdz_pkg::OP_RAD3: begin
        if (rs_side.mzero) begin
          fx_c = '0;
          fy_c = '0;
          fz_c = '0;
        end else begin
          fx_c = apply_sign(rs_side.it.x[N-1], rs_quo[0]);
          fy_c = apply_sign(rs_side.it.y[N-1], rs_quo[1]);
          fz_c = apply_sign(rs_side.it.z[N-1], rs_quo[2]);
        end
      end
      default: begin
        fx_c = rs_side.it.x;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  logic         res_valid_r;
  logic [N-1:0] res_x_r, res_y_r, res_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= rs_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r <= fx_c;
      res_y_r <= fy_c;
      res_z_r <= fz_c;
    end
  end

  assign res_valid = res_valid_r;
  assign res_x     = res_x_r;
  assign res_y     = res_y_r;
  assign res_z     = res_z_r;

endmodule

// File: design/stick_dead_zone_top.sv
// Stick dead zone: shapes one stick sample (kind plus three signed Q2.14 axes)
// through an axial or radial dead zone and returns the shaped axes.
// Channels: in_ch carries value_kind, x_in, y_in, z_in; out_ch carries x_out,
// y_out, z_out. Both use valid/ready; a request moves when both are high.
// Configuration: cfg_we writes cfg_data into register cfg_idx (0 player
// attached, 1 radial mode, 2 lower threshold, 3 upper threshold); write only
// while no request is in flight.
// Throughput: one request per cycle, sustained while the receiver does not stall.
// Path to out_ch.valid: queue, square and sum registers, square-root stages
// (one root bit each), setup register, shaping divider (14 quotient bits), ratio
// and scale registers, rescale divider (15 quotient bits), result register.
// A four-entry queue sits between the classifying front and the datapath.
// Stall: a held result freezes the datapath; the queue then fills and in_ch
// ready drops only once it is full.
// Reset: clears all valid flags and the queue and loads the registers with
// player attached, axial mode, lower 3277 and upper 16384.
module stick_dead_zone_top #(
  parameter int SAMPLE_BITS = sdz_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sdz_in_if.sink                              in_ch,
  sdz_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [sdz_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [sdz_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int N  = SAMPLE_BITS;
  localparam int FW = $bits(sdz_pkg::op_t) + 6 * N;

  // Configuration registers
  sdz_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.player_attached <= 1'b1;
      cfg_r.radial_mode     <= 1'b0;
      cfg_r.lower           <= sdz_pkg::LOWER_RST;
      cfg_r.upper           <= sdz_pkg::UPPER_RST;
    end else if (cfg_we) begin
      case (sdz_pkg::cfg_idx_t'(cfg_idx))
        sdz_pkg::CFG_PLAYER: cfg_r.player_attached <= cfg_data[0];
        sdz_pkg::CFG_RADIAL: cfg_r.radial_mode     <= cfg_data[0];
        sdz_pkg::CFG_LOWER:  cfg_r.lower           <= cfg_data;
        sdz_pkg::CFG_UPPER:  cfg_r.upper           <= cfg_data;
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  // Front: classify the incoming request
  sdz_pkg::op_t        f_op;
  logic signed [N-1:0] f_x, f_y, f_z;
  logic [N-1:0]        f_ax, f_ay, f_az;

  sdz_front #(.SAMPLE_BITS(N)) u_front (
    .cfg  (cfg_r),
    .kind (in_ch.value_kind),
    .x    (in_ch.x_in),
    .y    (in_ch.y_in),
    .z    (in_ch.z_in),
    .op   (f_op),
    .xo   (f_x),
    .yo   (f_y),
    .zo   (f_z),
    .ax   (f_ax),
    .ay   (f_ay),
    .az   (f_az)
  );

  // Queue between front and datapath
  logic          q_full, q_empty, q_pop, q_push;
  logic [FW-1:0] q_din, q_dout;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_din       = {f_op, f_x, f_y, f_z, f_ax, f_ay, f_az};

  sdz_fifo #(.W(FW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: shaping datapath
  sdz_pkg::op_t        b_op;
  logic signed [N-1:0] b_x, b_y, b_z;
  logic [N-1:0]        b_ax, b_ay, b_az;

  assign b_op = sdz_pkg::op_t'(q_dout[FW-1 -: $bits(sdz_pkg::op_t)]);
  assign b_x  = q_dout[6*N-1 -: N];
  assign b_y  = q_dout[5*N-1 -: N];
  assign b_z  = q_dout[4*N-1 -: N];
  assign b_ax = q_dout[3*N-1 -: N];
  assign b_ay = q_dout[2*N-1 -: N];
  assign b_az = q_dout[N-1:0];

  sdz_back #(.SAMPLE_BITS(N)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .src_valid (!q_empty),
    .src_pop   (q_pop),
    .src_op    (b_op),
    .src_x     (b_x),
    .src_y     (b_y),
    .src_z     (b_z),
    .src_ax    (b_ax),
    .src_ay    (b_ay),
    .src_az    (b_az),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_x     (out_ch.x_out),
    .res_y     (out_ch.y_out),
    .res_z     (out_ch.z_out)
  );

endmodule

// File: tb/sv/tb_stick_dead_zone_top.sv
`timescale 1ns / 100ps

module tb_stick_dead_zone_top;

  localparam int SB          = sdz_pkg::SAMPLE_BITS_DEF;
  localparam int TW          = sdz_pkg::THR_BITS;
  localparam int WATCH_LIMIT = 5000;
  localparam int DRAIN_WAIT  = SB + 45;

  typedef struct {
    logic signed [SB-1:0] x;
    logic signed [SB-1:0] y;
    logic signed [SB-1:0] z;
  } axes_t;

  // One directed row: either a register write or a sample
  typedef struct {
    bit                        is_write;
    sdz_pkg::cfg_idx_t         idx;
    logic [TW-1:0]             data;
    sdz_pkg::kind_t            kind;
    logic signed [SB-1:0]      x;
    logic signed [SB-1:0]      y;
    logic signed [SB-1:0]      z;
    bit                        typed;
    logic signed [SB-1:0]      ex;
    logic signed [SB-1:0]      ey;
    logic signed [SB-1:0]      ez;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  sdz_pkg::cfg_idx_t cfg_idx;
  logic [sdz_pkg::CFG_DATA_BITS-1:0] cfg_data;

  sdz_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  sdz_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  stick_dead_zone_top #(.SAMPLE_BITS(SB)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the dead-zone registers
  bit            shd_player;
  bit            shd_radial;
  logic [TW-1:0] shd_lower;
  logic [TW-1:0] shd_upper;

  axes_t     pending_shaped[$];
  stim_row_t stim_tab[$];
  int        err_count;
  int        idle_cycles;
  bit        calm;
  int        stall_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Dead-zone ratio of a non-negative magnitude, Q2.14
  function automatic longint dz_ratio(longint mag);
    longint lo;
    longint hi;
    longint q;
    lo = (shd_lower > sdz_pkg::ONE_Q14) ? longint'(sdz_pkg::ONE_Q14) : longint'(shd_lower);
    hi = longint'(shd_upper);
    if (mag <= lo) return 0;
    if (hi <= lo) return 16384;
    q = ((mag - lo) * 16384) / (hi - lo);
    return (q > 16384) ? 16384 : q;
  endfunction

  function automatic longint shaped_axis(longint v);
    return (v < 0) ? -dz_ratio(-v) : dz_ratio(v);
  endfunction

  function automatic longint floor_root(longint n);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint scaled_axis(longint a, longint s, longint m);
    longint r;
    r = (((a < 0) ? -a : a) * s) / m;
    return (a < 0) ? -r : r;
  endfunction

  function automatic axes_t predict_shaped_sample(sdz_pkg::kind_t kind,
                                                  logic signed [SB-1:0] xi,
                                                  logic signed [SB-1:0] yi,
                                                  logic signed [SB-1:0] zi);
    longint x;
    longint y;
    longint z;
    longint m;
    longint s;
    axes_t r;
    x = longint'(xi);
    y = longint'(yi);
    z = longint'(zi);
    if (kind != sdz_pkg::KIND_BOOL && shd_player) begin
      if (!shd_radial) begin
        x = shaped_axis(x);
        y = shaped_axis(y);
        z = shaped_axis(z);
      end else if (kind == sdz_pkg::KIND_1D) begin
        x = shaped_axis(x);
      end else begin
        if (kind != sdz_pkg::KIND_3D) z = 0;
        m = floor_root(x * x + y * y + z * z);
        if (m == 0) begin
          x = 0;
          y = 0;
          z = 0;
        end else begin
          s = dz_ratio(m);
          x = scaled_axis(x, s, m);
          y = scaled_axis(y, s, m);
          z = scaled_axis(z, s, m);
        end
      end
    end
    r.x = x[SB-1:0];
    r.y = y[SB-1:0];
    r.z = z[SB-1:0];
    return r;
  endfunction

  // Drop valid, wait until every result is back, then write one register
  task automatic write_reg(sdz_pkg::cfg_idx_t idx, logic [TW-1:0] data);
    in_ch.valid <= 1'b0;
    while (pending_shaped.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdz_pkg::CFG_PLAYER: shd_player = data[0];
      sdz_pkg::CFG_RADIAL: shd_radial = data[0];
      sdz_pkg::CFG_LOWER:  shd_lower  = data;
      default:             shd_upper  = data;
    endcase
    @(posedge clk);
  endtask

  // Offer one request (after a random idle gap unless calm) and hold it until accepted, then queue its expectation
  task automatic send_sample(sdz_pkg::kind_t kind, logic signed [SB-1:0] x,
                             logic signed [SB-1:0] y, logic signed [SB-1:0] z,
                             output axes_t exp_r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value_kind <= kind;
    in_ch.x_in       <= x;
    in_ch.y_in       <= y;
    in_ch.z_in       <= z;
    do @(posedge clk); while (!in_ch.ready);
    exp_r = predict_shaped_sample(kind, x, y, z);
    pending_shaped.push_back(exp_r);
  endtask

  function automatic logic signed [SB-1:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return SB'(($urandom_range(0, 2) == 0) ? -32768 :
                    (($urandom_range(0, 1) == 0) ? 32767 : 0));
      1: return SB'(int'($urandom_range(0, 8000)) - 4000);
      2: return SB'(int'(shd_lower) + int'($urandom_range(0, 6)) - 3);
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [TW-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return sdz_pkg::ONE_Q14;
      2: return 15'h7fff;
      3: return TW'($urandom_range(0, 16384));
      default: return TW'($urandom());
    endcase
  endfunction

  // Hold result ready low in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    axes_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_shaped.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 out_ch.x_out, out_ch.y_out, out_ch.z_out);
        err_count++;
      end else begin
        e = pending_shaped.pop_front();
        if (out_ch.x_out !== e.x) begin
          $display("%0t: x_out expected %0d actual %0d", $time, e.x, out_ch.x_out);
          err_count++;
        end
        if (out_ch.y_out !== e.y) begin
          $display("%0t: y_out expected %0d actual %0d", $time, e.y, out_ch.y_out);
          err_count++;
        end
        if (out_ch.z_out !== e.z) begin
          $display("%0t: z_out expected %0d actual %0d", $time, e.z, out_ch.z_out);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    axes_t got;
    stim_row_t r;
    sdz_pkg::kind_t k;
    err_count = 0;
    idle_cycles = 0;
    calm = 1'b0;
    stall_left = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = sdz_pkg::CFG_PLAYER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.value_kind = sdz_pkg::KIND_BOOL;
    in_ch.x_in = '0;
    in_ch.y_in = '0;
    in_ch.z_in = '0;
    out_ch.ready = 1'b0;
    shd_player = 1'b1;
    shd_radial = 1'b0;
    shd_lower  = sdz_pkg::LOWER_RST;
    shd_upper  = sdz_pkg::UPPER_RST;

    // Directed rows: reset values first, then each special case
    stim_tab = '{
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_BOOL, -32768, 32767, 5, 1, -32768, 32767, 5},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, 32767, -32768, 0, 1, 16384, -16384, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, 3277, -3277, 3278, 1, 0, 0, 1},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_1D, 100, 20000, -20000, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_2D, 7000, -9000, 12000, 0, 0, 0, 0},
      '{1, sdz_pkg::CFG_RADIAL, 1, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, 0, 0, 0, 1, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_2D, 0, 0, 123, 1, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_1D, -32768, 5, -7, 1, -16384, 5, -7},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_2D, 10000, 10000, 999, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, -32768, -32768, -32768, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, 1, 1, 1, 0, 0, 0, 0},
      '{1, sdz_pkg::CFG_UPPER, 1000, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{1, sdz_pkg::CFG_LOWER, 2000, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_1D, 2001, 9, 9, 1, 16384, 9, 9},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_1D, -2000, 9, 9, 1, 0, 9, 9},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, 1500, -1500, 900, 0, 0, 0, 0},
      '{1, sdz_pkg::CFG_RADIAL, 0, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_2D, 2000, -2001, 32767, 1, 0, -16384, 16384},
      '{1, sdz_pkg::CFG_UPPER, 2000, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_1D, 2001, 2000, -2001, 1, 16384, 0, -16384},
      '{1, sdz_pkg::CFG_LOWER, 15'h7fff, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{1, sdz_pkg::CFG_UPPER, 15'h7fff, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, 16384, 16385, -32767, 1, 0, 1, -16384},
      '{1, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_3D, 123, -32768, 32767, 1, 123, -32768, 32767},
      '{1, sdz_pkg::CFG_PLAYER, 1, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{1, sdz_pkg::CFG_LOWER, 0, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{1, sdz_pkg::CFG_UPPER, 0, sdz_pkg::KIND_BOOL, 0, 0, 0, 0, 0, 0, 0},
      '{0, sdz_pkg::CFG_PLAYER, 0, sdz_pkg::KIND_2D, 1, 0, -1, 1, 16384, 0, -16384}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (stim_tab[i]) begin
      r = stim_tab[i];
      if (r.is_write) begin
        write_reg(r.idx, r.data);
      end else begin
        send_sample(r.kind, r.x, r.y, r.z, got);
        if (r.typed && (got.x !== r.ex || got.y !== r.ey || got.z !== r.ez)) begin
          $display("%0t: row %0d expected %0d %0d %0d actual %0d %0d %0d", $time, i,
                   r.ex, r.ey, r.ez, got.x, got.y, got.z);
          err_count++;
        end
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      write_reg(sdz_pkg::CFG_PLAYER, TW'((p == 3) ? 0 : 1));
      write_reg(sdz_pkg::CFG_RADIAL, TW'(p % 2));
      write_reg(sdz_pkg::CFG_LOWER, (p == 0) ? '0 : pick_threshold());
      write_reg(sdz_pkg::CFG_UPPER, (p == 0) ? 15'h7fff : pick_threshold());
      calm = (p == 7);
      for (int n = 0; n < 50; n++) begin
        k = sdz_pkg::kind_t'($urandom_range(0, 3));
        send_sample(k, pick_axis(), pick_axis(), pick_axis(), got);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_shaped.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
